[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is asserted.
`define ASSERT_AT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_AT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

[rtl/core/fir_lp_pkg.sv]
// Shared constants, types and the coefficient ROM of the low-pass FIR filter.
// No dependencies; imported by fir_lp_ctrl, fir_lp_mac and the top level.
`timescale 1ns / 1ps

package fir_lp_pkg;

	localparam int DEF_TAPS         = 16;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int COEF_W           = 16;
	localparam int COEF_FRAC        = 15;
	localparam int ROM_DEPTH        = 64;
	localparam int ROM_AW           = $clog2(ROM_DEPTH);

	// Control that travels with one tap from the sequencer to the datapath.
	typedef struct packed {
		logic              vld;
		logic              first;
		logic              last;
		logic              hist_vld;
		logic [COEF_W-1:0] coef;
	} tap_ctl_t;

	// Q1.15 coefficients of the low-pass response; taps past the
	// sixteenth weigh zero.
	function automatic logic signed [COEF_W-1:0] coef_rom(input logic [ROM_AW-1:0] n);
		logic signed [COEF_W-1:0] c;
		case (n)
			0:       c = -16'sd108;
			1:       c = -16'sd172;
			2:       c = -16'sd225;
			3:       c = 16'sd0;
			4:       c = 16'sd833;
			5:       c = 16'sd2375;
			6:       c = 16'sd4297;
			7:       c = 16'sd5918;
			8:       c = 16'sd6554;
			9:       c = 16'sd5918;
			10:      c = 16'sd4297;
			11:      c = 16'sd2375;
			12:      c = 16'sd833;
			13:      c = 16'sd0;
			14:      c = -16'sd225;
			15:      c = -16'sd172;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/fir_lp_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fir_lp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/fir_lp_ctrl.sv]
// Sequencer of the FIR filter: write pointer, history valid bits, tap read
// addresses, coefficient lookup and output hand-off. Uses fir_lp_pkg.
`timescale 1ns / 1ps

module fir_lp_ctrl
	import fir_lp_pkg::*;
#(
	parameter int TAPS = DEF_TAPS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    wr_en,
	output logic [$clog2(TAPS)-1:0] wr_addr,
	output logic                    rd_en,
	output logic [$clog2(TAPS)-1:0] rd_addr,
	output tap_ctl_t                ctl_s1,
	input  logic                    acc_done,
	input  logic                    out_free,
	output logic                    load
);

	localparam int AW = $clog2(TAPS);
	localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_LOAD  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] cnt_q;
	logic [TAPS-1:0] valid_q;
	logic          accept;
	logic          last_tap;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept;
	assign wr_addr  = wp_q;
	assign rd_en    = (state_q == ST_READ);
	assign rd_addr  = rd_addr_q;
	assign last_tap = (cnt_q == LAST_IDX);

	always_comb begin
		case (state_q)
			ST_DRAIN: load = acc_done && out_free;
			ST_LOAD:  load = out_free;
			default:  load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rd_addr_q <= '0;
			cnt_q     <= '0;
			valid_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valid_q[wp_q] <= 1'b1;
						rd_addr_q     <= wp_q;
						wp_q          <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
						cnt_q         <= '0;
						state_q       <= ST_READ;
					end
				end
				ST_READ: begin
					rd_addr_q <= (rd_addr_q == '0) ? LAST_IDX : rd_addr_q - 1'b1;
					cnt_q     <= cnt_q + 1'b1;
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (acc_done) begin
						state_q <= out_free ? ST_IDLE : ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Tap control lines up with the registered read data of the history RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld      <= (state_q == ST_READ);
			ctl_s1.first    <= (cnt_q == '0);
			ctl_s1.last     <= last_tap;
			ctl_s1.hist_vld <= valid_q[rd_addr_q];
			ctl_s1.coef     <= coef_rom(ROM_AW'(cnt_q));
		end
	end

endmodule

[rtl/core/fir_lp_mac.sv]
// Multiply-accumulate datapath of the FIR filter, with round-half-up and
// saturation of the final sum. Uses fir_lp_pkg.
`timescale 1ns / 1ps

module fir_lp_mac
	import fir_lp_pkg::*;
#(
	parameter int TAPS         = DEF_TAPS,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tap_ctl_t                ctl_s1,
	input  logic [SAMPLE_WIDTH-1:0] rd_data,
	output logic                    acc_done,
	output logic [SAMPLE_WIDTH-1:0] result
);

	localparam int PW    = SAMPLE_WIDTH + COEF_W;
	localparam int ACC_W = PW + $clog2(TAPS);
	localparam int RW    = ACC_W - COEF_FRAC;
	localparam logic [ACC_W-1:0] RND_HALF =
		{{(ACC_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
	localparam logic [RW-1:0] SAT_HI =
		{{(RW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic [RW-1:0] SAT_LO =
		{{(RW - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic signed [PW-1:0]           prod_s2;
	logic                           vld_s2;
	logic                           first_s2;
	logic                           last_s2;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        prod_ext;
	logic signed [ACC_W-1:0]        rnd_sum;
	logic signed [RW-1:0]           rounded;

	// Entries never written since reset count as zero samples.
	assign sample_s1 = ctl_s1.hist_vld ? $signed(rd_data) : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= sample_s1 * $signed(ctl_s1.coef);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			acc_done <= 1'b0;
		end else begin
			vld_s2   <= ctl_s1.vld;
			first_s2 <= ctl_s1.first;
			last_s2  <= ctl_s1.last;
			acc_done <= vld_s2 && last_s2;
		end
	end

	assign prod_ext = {{(ACC_W - PW){prod_s2[PW-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
	end

	assign rnd_sum = acc_q + $signed(RND_HALF);
	assign rounded = rnd_sum[ACC_W-1:COEF_FRAC];

	always_comb begin
		if (rounded > $signed(SAT_HI)) begin
			result = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (rounded < $signed(SAT_LO)) begin
			result = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			result = rounded[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

[rtl/core/fir_lowpass_16_tap.sv]
// Top level of the fixed-coefficient low-pass FIR filter; instantiates
// fir_lp_ram, fir_lp_ctrl and fir_lp_mac, uses fir_lp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Low-pass FIR filter with TAPS taps (sixteen by default) and Q1.15 samples.
// Each sample transfer on the input channel stores the sample in a circular
// history RAM and yields exactly one filtered sample on the output channel:
// the sum of coefficient n times the sample n steps back, the newest sample
// pairing with coefficient 0, rounded half up from the Q6.30 sum to Q1.15 and
// saturated to the signed SAMPLE_WIDTH-bit range. The history reads as zero
// after reset until each slot has been written, so no clearing pass is needed
// and the block is ready right after reset. One multiplier is shared by all
// taps: the history RAM is read one tap per cycle, and one sample occupies the
// block through the reads of all TAPS taps and the three-stage read, multiply
// and accumulate path. The input accepts the next sample while a finished
// result still waits in the output register; a result is held there until the
// downstream side takes it, and the filter stalls only when a new result is
// ready and the old one is still waiting.
module fir_lowpass_16_tap
	import fir_lp_pkg::*;
#(
	parameter int TAPS         = DEF_TAPS,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] sample_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0] filtered_out
);

	localparam int AW = $clog2(TAPS);

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [SAMPLE_WIDTH-1:0] rd_data;
	tap_ctl_t                ctl_s1;
	logic                    acc_done;
	logic                    out_free;
	logic                    load;
	logic [SAMPLE_WIDTH-1:0] result;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] filtered_q;

	// The output register is free when empty or when its result transfers now.
	assign out_free = !out_valid_q || out_ready;

	fir_lp_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (TAPS)
	) u_hist_ram (
		.clk     (clk),
		.we      (wr_en),
		.wr_addr (wr_addr),
		.wr_data (sample_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fir_lp_ctrl #(
		.TAPS (TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.ctl_s1   (ctl_s1),
		.acc_done (acc_done),
		.out_free (out_free),
		.load     (load)
	);

	fir_lp_mac #(
		.TAPS         (TAPS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.rd_data  (rd_data),
		.acc_done (acc_done),
		.result   (result)
	);

	// Output register: loaded with the rounded and saturated sum, cleared
	// when its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			filtered_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_out = filtered_q;

	// A result must never overwrite one that has not transferred yet.
	`ASSERT_AT_CLK(a_no_overwrite, clk, arst_n, load |-> out_free, "result register overwritten")
	// Only one sample is in flight: the input closes right after a transfer.
	`ASSERT_AT_CLK(a_one_in_flight, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "second sample accepted while busy")
	// A result is loaded only while a sample is being processed.
	`ASSERT_NEVER(a_no_load_idle, clk, arst_n, load && in_ready, "result loaded while idle")

endmodule
